### rtl/core/periodic_software_timer_table_core_defines.svh
// Assertion macros used by the timer table core.
`ifndef PERIODIC_SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH
`define PERIODIC_SOFTWARE_TIMER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PSTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pstt_pkg.sv
// Shared types and constants for the periodic timer table.
`timescale 1ns / 1ps
`default_nettype none
package pstt_pkg;

  localparam int TIMER_SLOTS_DEF = 8;
  localparam int TIME_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int SLOT_OUT_W      = 6;
  localparam int MASK_W          = 8;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_IVL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

  // One timer entry as it travels around the ring of cells.
  typedef struct packed {
    logic              used;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last;
  } entry_t;

endpackage
`default_nettype wire

### rtl/core/pstt_cell.sv
// One timer cell of the rotating ring: holds an entry, loads or shifts it.
`timescale 1ns / 1ps
`default_nettype none
module pstt_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              shift,
  input  wire logic                              load,
  input  wire logic [pstt_pkg::TIME_W-1:0]       load_period,
  input  wire pstt_pkg::entry_t                  from_next,
  output pstt_pkg::entry_t                       entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.used <= 1'b0;
    end else if (shift) begin
      entry <= from_next;
    end else if (load) begin
      entry.period <= load_period;
      entry.last   <= '0;
      entry.used   <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/periodic_software_timer_table_core.sv
// Top level of the periodic timer table: command decode, tick scan and result.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  command   | start / busy           | opcode, interval
//  result    | strobe (one cycle)     | kind, status, slot, fire_mask, time_now
//
// A register command answers with strobe in the cycle after acceptance; busy stays low.
// A tick command rotates the ring of TIMER_SLOTS cells once past a single
// add/compare unit at the head; strobe is raised once the scan ends.
// busy is high for the whole scan, so no new command is taken during a tick.
// Synchronous reset clears the tick counter, fill count and cell used bits.
// Results cannot be stalled; the receiver takes each strobe beat as it comes.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_software_timer_table_core_defines.svh"
module periodic_software_timer_table_core #(
  parameter int TIMER_SLOTS = pstt_pkg::TIMER_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                opcode,
  input  wire logic [pstt_pkg::TIME_W-1:0]         interval,
  output logic                                     strobe,
  output logic                                     kind,
  output logic [pstt_pkg::STATUS_W-1:0]            status,
  output logic [pstt_pkg::SLOT_OUT_W-1:0]          slot,
  output logic [pstt_pkg::MASK_W-1:0]              fire_mask,
  output logic [pstt_pkg::TIME_W-1:0]              time_now
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                          state;
  logic [pstt_pkg::TIME_W-1:0]     tick_count;
  logic [CNT_W-1:0]                used_count;
  logic [SLOT_W-1:0]               step;
  logic [pstt_pkg::MASK_W-1:0]     mask_acc;
  logic [pstt_pkg::MASK_W-1:0]     bit_sel;

  pstt_pkg::entry_t                cells   [TIMER_SLOTS];
  pstt_pkg::entry_t                head_upd;
  logic [pstt_pkg::TIME_W-1:0]     head_sum;
  logic                            head_fire;

  logic                            accept;
  logic                            ivl_zero;
  logic                            tbl_full;
  logic                            reg_ok;
  logic                            scanning;
  logic                            acc_reg;
  logic                            acc_tick;
  logic                            reg_beat;

  assign scanning = (state == SCAN);
  assign busy     = scanning;
  assign accept   = start && !busy;
  assign ivl_zero = (interval == '0);
  assign tbl_full = (used_count >= CNT_W'(TIMER_SLOTS));
  assign reg_ok   = accept && (opcode == pstt_pkg::OP_REGISTER) && !ivl_zero && !tbl_full;
  assign acc_reg  = accept && (opcode == pstt_pkg::OP_REGISTER);
  assign acc_tick = accept && (opcode == pstt_pkg::OP_TICK);
  assign reg_beat = strobe && (kind == pstt_pkg::OP_REGISTER);

  // Head evaluation: fire test, then drop a last-fire time that lies ahead of now.
  assign head_sum  = cells[0].last + cells[0].period;
  assign head_fire = cells[0].used && (head_sum <= tick_count);

  always_comb begin
    head_upd = cells[0];
    if (head_fire) begin
      head_upd.last = tick_count;
    end else if (cells[0].used && (cells[0].last > tick_count)) begin
      head_upd.last = '0;
    end
  end

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    pstt_pkg::entry_t from_next;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign from_next = head_upd;
    end else begin : g_mid
      assign from_next = cells[i+1];
    end
    pstt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (scanning),
      .load        (reg_ok && (used_count[SLOT_W-1:0] == SLOT_W'(i))),
      .load_period (interval),
      .from_next   (from_next),
      .entry       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      strobe     <= 1'b0;
      tick_count <= '0;
      used_count <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            if (opcode == pstt_pkg::OP_REGISTER) begin
              strobe    <= 1'b1;
              kind      <= pstt_pkg::OP_REGISTER;
              fire_mask <= '0;
              time_now  <= tick_count;
              slot      <= '0;
              if (ivl_zero) begin
                status <= pstt_pkg::ST_ZERO_IVL;
              end else if (tbl_full) begin
                status <= pstt_pkg::ST_TABLE_FULL;
              end else begin
                status     <= pstt_pkg::ST_OK;
                slot       <= pstt_pkg::SLOT_OUT_W'(used_count);
                used_count <= used_count + 1'b1;
              end
            end else begin
              tick_count <= tick_count + 1'b1;
              step       <= '0;
              mask_acc   <= '0;
              bit_sel    <= pstt_pkg::MASK_W'(1);
              state      <= SCAN;
            end
          end
        end
        SCAN: begin
          step    <= step + 1'b1;
          bit_sel <= bit_sel << 1;
          if (head_fire) begin
            mask_acc <= mask_acc | bit_sel;
          end
          if (step == SLOT_W'(TIMER_SLOTS - 1)) begin
            // Ring is back in slot order: publish the tick answer.
            state     <= IDLE;
            strobe    <= 1'b1;
            kind      <= pstt_pkg::OP_TICK;
            status    <= pstt_pkg::ST_OK;
            slot      <= '0;
            fire_mask <= mask_acc | (head_fire ? bit_sel : '0);
            time_now  <= tick_count;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `PSTT_ASSERT_NOW(a_strobe_idle, strobe, !busy, "result beat during tick scan")
  `PSTT_ASSERT_NEXT(a_tick_scans, acc_tick, busy && !strobe, "tick did not start scan")
  `PSTT_ASSERT_NEXT(a_reg_answers, acc_reg, reg_beat, "register command without answer")
  `PSTT_ASSERT_NOW(a_fill_bound, 1'b1, used_count <= CNT_W'(TIMER_SLOTS), "fill count beyond table size")
  `PSTT_ASSERT_NOW(a_reg_no_mask, reg_beat, fire_mask == '0, "register answer with fire bits")

endmodule
`default_nettype wire

### tb/periodic_software_timer_table_core_tb.sv
// Self-checking bench for the periodic timer table: directed plan, random beats, scoreboard.
`timescale 1ns / 1ps
module periodic_software_timer_table_core_tb;

  localparam int SLOTS        = pstt_pkg::TIMER_SLOTS_DEF;
  localparam int RANDOM_BEATS = 1430;
  localparam int TIME_W       = pstt_pkg::TIME_W;
  localparam int STATUS_W     = pstt_pkg::STATUS_W;
  localparam int SLOT_OUT_W   = pstt_pkg::SLOT_OUT_W;
  localparam int MASK_W       = pstt_pkg::MASK_W;

  localparam logic                OP_REG  = pstt_pkg::OP_REGISTER;
  localparam logic                OP_TCK  = pstt_pkg::OP_TICK;
  localparam logic [STATUS_W-1:0] S_OK    = pstt_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] S_ZERO  = pstt_pkg::ST_ZERO_IVL;
  localparam logic [STATUS_W-1:0] S_FULL  = pstt_pkg::ST_TABLE_FULL;

  typedef struct packed {
    logic                  kind;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [MASK_W-1:0]     fire_mask;
    logic [TIME_W-1:0]     time_now;
  } answer_t;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] ivl;
    logic              pinned;
    answer_t           res;
  } plan_row_t;

  localparam answer_t NO_ANSWER = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  opcode = OP_REG;
  logic [TIME_W-1:0]     interval = '0;
  logic                  busy;
  logic                  strobe;
  logic                  kind;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [MASK_W-1:0]     fire_mask;
  logic [TIME_W-1:0]     time_now;

  // Typed-in answer for the beat currently offered, used instead of the prediction.
  logic    pin_now = 1'b0;
  answer_t pin_answer = '0;

  answer_t due_answers [$];
  int      mismatches = 0;

  // Timer table state as the bench tracks it.
  logic [TIME_W-1:0] ticks;
  logic [TIME_W-1:0] period_of    [SLOTS];
  logic [TIME_W-1:0] last_fire_of [SLOTS];
  logic              slot_taken   [SLOTS];
  int unsigned       taken_count;

  periodic_software_timer_table_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic answer_t timer_table_answer(input logic op, input logic [TIME_W-1:0] ivl);
    answer_t           a;
    logic [TIME_W-1:0] due;
    a = '0;
    a.kind = op;
    if (op == OP_REG) begin
      if (ivl == '0) begin
        a.status = S_ZERO;
      end else if (taken_count >= SLOTS) begin
        a.status = S_FULL;
      end else begin
        a.slot = SLOT_OUT_W'(taken_count);
        period_of[taken_count]    = ivl;
        last_fire_of[taken_count] = '0;
        slot_taken[taken_count]   = 1'b1;
        taken_count++;
      end
    end else begin
      ticks = ticks + 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_taken[i]) begin
          // deadline wraps modulo 2^32 like the counter
          due = last_fire_of[i] + period_of[i];
          if (due <= ticks) begin
            last_fire_of[i] = ticks;
            if (i < MASK_W) a.fire_mask[i] = 1'b1;
          end
          if (last_fire_of[i] > ticks) last_fire_of[i] = '0;
        end
      end
    end
    a.time_now = ticks;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t seen;
    answer_t want;
    if (!rst) begin
      if (strobe === 1'b1) begin
        seen = {kind, status, slot, fire_mask, time_now};
        if (due_answers.size() == 0) begin
          flag_mismatch("answer beat with nothing pending");
        end else begin
          want = due_answers.pop_front();
          if (seen.kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d", seen.kind, want.kind));
          if (seen.status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", seen.status, want.status));
          if (seen.slot !== want.slot)
            flag_mismatch($sformatf("slot got %0d want %0d", seen.slot, want.slot));
          if (seen.fire_mask !== want.fire_mask)
            flag_mismatch($sformatf("fire_mask got %h want %h", seen.fire_mask,
                                    want.fire_mask));
          if (seen.time_now !== want.time_now)
            flag_mismatch($sformatf("time_now got %0d want %0d", seen.time_now,
                                    want.time_now));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = timer_table_answer(opcode, interval);
        due_answers.push_back(pin_now ? pin_answer : want);
      end
    end
  end

  // Called and left at a falling edge; start stays high for a back-to-back beat.
  task automatic send_beat(input logic op, input logic [TIME_W-1:0] ivl, input logic pin,
                           input answer_t res, input bit may_idle);
    if (may_idle && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    interval   <= ivl;
    pin_now     = pin;
    pin_answer  = res;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Hold off the sender until every pending answer has come back.
  task automatic drain_hold();
    start <= 1'b0;
    do @(negedge clk); while (due_answers.size() != 0);
  endtask

  initial begin
    plan_row_t         plan [$];
    logic              op;
    logic [TIME_W-1:0] ivl;
    ticks       = '0;
    taken_count = 0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;

    //             op      interval       pin   kind    status  slot  mask   time
    plan.push_back({OP_TCK, 32'h0000_0000, 1'b1, OP_TCK, S_OK,   6'd0, 8'h00, 32'd1});
    plan.push_back({OP_REG, 32'h0000_0000, 1'b1, OP_REG, S_ZERO, 6'd0, 8'h00, 32'd1});
    plan.push_back({OP_REG, 32'h0000_0001, 1'b1, OP_REG, S_OK,   6'd0, 8'h00, 32'd1});
    plan.push_back({OP_TCK, 32'hFFFF_FFFF, 1'b1, OP_TCK, S_OK,   6'd0, 8'h01, 32'd2});
    plan.push_back({OP_REG, 32'hFFFF_FFFF, 1'b1, OP_REG, S_OK,   6'd1, 8'h00, 32'd2});
    plan.push_back({OP_REG, 32'h8000_0000, 1'b1, OP_REG, S_OK,   6'd2, 8'h00, 32'd2});
    plan.push_back({OP_REG, 32'h0000_0003, 1'b0, NO_ANSWER});
    plan.push_back({OP_REG, 32'h0000_0002, 1'b0, NO_ANSWER});
    plan.push_back({OP_REG, 32'h0000_0005, 1'b0, NO_ANSWER});
    plan.push_back({OP_REG, 32'h0000_0007, 1'b0, NO_ANSWER});
    plan.push_back({OP_REG, 32'h0000_0001, 1'b1, OP_REG, S_OK,   6'd7, 8'h00, 32'd2});
    plan.push_back({OP_REG, 32'h0000_0005, 1'b1, OP_REG, S_FULL, 6'd0, 8'h00, 32'd2});
    plan.push_back({OP_REG, 32'h0000_0000, 1'b1, OP_REG, S_ZERO, 6'd0, 8'h00, 32'd2});
    plan.push_back({OP_REG, 32'hFFFF_FFFF, 1'b1, OP_REG, S_FULL, 6'd0, 8'h00, 32'd2});
    repeat (8) plan.push_back({OP_TCK, 32'h0000_0000, 1'b0, NO_ANSWER});
    plan.push_back({OP_REG, 32'h5555_AAAA, 1'b0, NO_ANSWER});
    plan.push_back({OP_TCK, 32'hAAAA_5555, 1'b0, NO_ANSWER});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) send_beat(plan[n].op, plan[n].ivl, plan[n].pinned, plan[n].res, 1'b1);
    drain_hold();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 900) drain_hold();
      if ($urandom_range(99) < 25) begin
        op  = OP_REG;
        ivl = ($urandom_range(9) == 0) ? '0 : $urandom;
      end else begin
        op  = OP_TCK;
        ivl = $urandom;
      end
      // no sender gaps across a long middle stretch
      send_beat(op, ivl, 1'b0, NO_ANSWER, !(n >= 300 && n < 700));
    end
    start <= 1'b0;

    for (int w = 0; w < 400 && due_answers.size() != 0; w++) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);
    if (due_answers.size() != 0)
      flag_mismatch($sformatf("%0d answers never arrived", due_answers.size()));

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
